### src/assert_macros.svh
// assertion macros shared by the frame envelope checker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define FEC_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("fec assertion failed");

// next-cycle implication, disabled during reset
`define FEC_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("fec assertion failed");

`endif

### src/fec_pkg.sv
// types, constants and helper functions of the frame envelope checker
package fec_pkg;

  localparam int POSITION_BITS = 23;
  localparam int FIELD_BITS    = 23;
  localparam int WORD_BITS     = 32;
  localparam int WIDE_BITS     = 34;

  localparam int HEADER_BYTES  = 64;
  localparam int ALIGN_BYTES   = 8;
  localparam logic [FIELD_BITS-1:0] ABS_MAX_FRAME = FIELD_BITS'(4194304);

  localparam logic [7:0] VERSION_BYTE = 8'd1;
  localparam logic [7:0] HDR_SIZE_BYTE = 8'(HEADER_BYTES);

  localparam logic [5:0] POS_VERSION  = 6'd8;
  localparam logic [5:0] POS_HDR_SIZE = 6'd12;
  localparam logic [5:0] POS_PROF_OFF = 6'd24;

  // header word lanes that are captured rather than compared
  localparam logic [3:0] LANE_TOTAL    = 4'd4;
  localparam logic [3:0] LANE_PROF_LEN = 4'd7;
  localparam logic [3:0] LANE_REQ_OFF  = 4'd8;
  localparam logic [3:0] LANE_REQ_LEN  = 4'd9;

  localparam logic [7:0] MAGIC [8] = '{8'h42, 8'h47, 8'h43, 8'h43,
                                       8'h41, 8'h42, 8'h49, 8'h31};

  localparam int RQ_DEPTH     = 4;
  localparam int RQ_PTR_BITS  = $clog2(RQ_DEPTH);
  localparam int CREDIT_BITS  = $clog2(RQ_DEPTH + 1);

  localparam int  CFG_ADDR_BITS = 3;
  localparam logic CFG_IDX_MAX_FRAME = 1'b0;

  typedef struct packed {
    logic                     hdr_good;
    logic                     pad_good;
    logic [POSITION_BITS-1:0] position;
    logic [WORD_BITS-1:0]     total;
    logic [WORD_BITS-1:0]     prof_len;
    logic [WORD_BITS-1:0]     req_off;
    logic [WORD_BITS-1:0]     req_len;
  } fec_snap_t;

  typedef struct packed {
    logic                  frame_ok;
    logic [FIELD_BITS-1:0] profile_base;
    logic [FIELD_BITS-1:0] profile_length;
    logic [FIELD_BITS-1:0] request_base;
    logic [FIELD_BITS-1:0] request_length;
  } fec_result_t;

  function automatic logic [7:0] fec_want_byte(input logic [5:0] hpos);
    logic [7:0] want;
    want = 8'd0;
    if (hpos < 6'd8) begin
      want = MAGIC[hpos[2:0]];
    end else if (hpos == POS_VERSION) begin
      want = VERSION_BYTE;
    end else if (hpos == POS_HDR_SIZE || hpos == POS_PROF_OFF) begin
      want = HDR_SIZE_BYTE;
    end
    return want;
  endfunction

  function automatic logic [WIDE_BITS-1:0] fec_round8(input logic [WIDE_BITS-1:0] v);
    logic [WIDE_BITS-1:0] sum;
    sum = v + WIDE_BITS'(ALIGN_BYTES - 1);
    return sum & ~WIDE_BITS'(ALIGN_BYTES - 1);
  endfunction

endpackage

### src/fec_byte_if.sv
// byte stream channel of the frame envelope checker
interface fec_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### src/fec_result_if.sv
// verdict channel of the frame envelope checker
interface fec_result_if
  import fec_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  frame_ok;
  logic [FIELD_BITS-1:0] profile_base;
  logic [FIELD_BITS-1:0] profile_length;
  logic [FIELD_BITS-1:0] request_base;
  logic [FIELD_BITS-1:0] request_length;

  modport source (output valid, output frame_ok, output profile_base,
                  output profile_length, output request_base,
                  output request_length, input ready);
  modport sink (input valid, input frame_ok, input profile_base,
                input profile_length, input request_base,
                input request_length, output ready);
endinterface

### src/fec_cfg.sv
// apb register holding the maximum frame length
module fec_cfg
  import fec_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [WORD_BITS-1:0]     pwdata,
  output logic [WORD_BITS-1:0]     prdata,
  output logic                     pready,
  output logic [FIELD_BITS-1:0]    max_frame_bytes
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == CFG_IDX_MAX_FRAME);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= ABS_MAX_FRAME;
    end else if (wr_en) begin
      max_frame_bytes <= pwdata[FIELD_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == CFG_IDX_MAX_FRAME) begin
      prdata = WORD_BITS'(max_frame_bytes);
    end
  end

endmodule

### src/fec_scan.sv
// per-byte header check, field capture and padding check
module fec_scan
  import fec_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  logic [7:0] data_byte,
  input  logic      last_byte,
  output logic      snap_valid,
  output fec_snap_t snap
);
  `include "assert_macros.svh"

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic                     s1_valid;
  logic [7:0]               s1_data;
  logic                     s1_last;

  logic [POSITION_BITS-1:0] position, position_next;
  logic                     hdr_good, hdr_good_next;
  logic                     pad_good, pad_good_next;
  logic [WORD_BITS-1:0]     total, total_next;
  logic [WORD_BITS-1:0]     prof_len, prof_len_next;
  logic [WORD_BITS-1:0]     req_off, req_off_next;
  logic [WORD_BITS-1:0]     req_len, req_len_next;

  logic                     in_header;
  logic [5:0]               hpos;
  logic [WORD_BITS-1:0]     lane_val;
  logic [WORD_BITS:0]       pos_w, prof_end, req_end;
  logic                     is_pad;

  assign in_header = position < POSITION_BITS'(HEADER_BYTES);
  assign hpos      = position[5:0];
  assign lane_val  = WORD_BITS'(s1_data) << {hpos[1:0], 3'b000};
  assign pos_w     = (WORD_BITS+1)'(position);
  assign prof_end  = (WORD_BITS+1)'(HEADER_BYTES) + {1'b0, prof_len};
  assign req_end   = {1'b0, req_off} + {1'b0, req_len};
  assign is_pad    = (pos_w >= prof_end && pos_w < {1'b0, req_off}) || pos_w >= req_end;

  always_comb begin
    position_next = position;
    hdr_good_next = hdr_good;
    pad_good_next = pad_good;
    total_next    = total;
    prof_len_next = prof_len;
    req_off_next  = req_off;
    req_len_next  = req_len;
    if (s1_valid) begin
      if (in_header) begin
        case (hpos[5:2])
          LANE_TOTAL:    total_next    = total | lane_val;
          LANE_PROF_LEN: prof_len_next = prof_len | lane_val;
          LANE_REQ_OFF:  req_off_next  = req_off | lane_val;
          LANE_REQ_LEN:  req_len_next  = req_len | lane_val;
          default: begin
            if (s1_data != fec_want_byte(hpos)) begin
              hdr_good_next = 1'b0;
            end
          end
        endcase
      end else if (is_pad && s1_data != 8'd0) begin
        pad_good_next = 1'b0;
      end
      if (position != POS_MAX) begin
        position_next = position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      snap_valid <= 1'b0;
      position   <= '0;
      hdr_good   <= 1'b1;
      pad_good   <= 1'b1;
      total      <= '0;
      prof_len   <= '0;
      req_off    <= '0;
      req_len    <= '0;
    end else begin
      s1_valid   <= take;
      snap_valid <= s1_valid && s1_last;
      if (s1_valid && s1_last) begin
        position <= '0;
        hdr_good <= 1'b1;
        pad_good <= 1'b1;
        total    <= '0;
        prof_len <= '0;
        req_off  <= '0;
        req_len  <= '0;
      end else begin
        position <= position_next;
        hdr_good <= hdr_good_next;
        pad_good <= pad_good_next;
        total    <= total_next;
        prof_len <= prof_len_next;
        req_off  <= req_off_next;
        req_len  <= req_len_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_data <= data_byte;
      s1_last <= last_byte;
    end
    if (s1_valid && s1_last) begin
      snap.hdr_good <= hdr_good_next;
      snap.pad_good <= pad_good_next;
      snap.position <= position;
      snap.total    <= total_next;
      snap.prof_len <= prof_len_next;
      snap.req_off  <= req_off_next;
      snap.req_len  <= req_len_next;
    end
  end

  `FEC_ASSERT_NXT(a_frame_restart, clk, rst, s1_valid && s1_last,
                  position == '0 && hdr_good && pad_good && snap_valid)
  `FEC_ASSERT_IMP(a_snap_only_on_last, clk, rst, snap_valid,
                  $past(s1_valid) && $past(s1_last))

endmodule

### src/fec_judge.sv
// end-of-frame verdict from the captured header fields
module fec_judge
  import fec_pkg::*;
(
  input  fec_snap_t             snap,
  input  logic [FIELD_BITS-1:0] max_frame_bytes,
  output fec_result_t           result
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [FIELD_BITS-1:0] limit;
  logic [WIDE_BITS-1:0]  len, prof_end, req_end, req_off_w;
  logic                  ok;

  always_comb begin
    limit     = (max_frame_bytes > ABS_MAX_FRAME) ? ABS_MAX_FRAME : max_frame_bytes;
    len       = WIDE_BITS'(snap.position) + WIDE_BITS'(1);
    prof_end  = WIDE_BITS'(HEADER_BYTES) + WIDE_BITS'(snap.prof_len);
    req_off_w = WIDE_BITS'(snap.req_off);
    req_end   = req_off_w + WIDE_BITS'(snap.req_len);
    ok = snap.hdr_good && snap.pad_good && (snap.position != POS_MAX)
      && len >= WIDE_BITS'(HEADER_BYTES) && len <= WIDE_BITS'(limit)
      && WIDE_BITS'(snap.total) == len
      && snap.prof_len != '0 && snap.req_len != '0
      && snap.req_off[2:0] == 3'd0
      && prof_end <= len && req_end <= len
      && req_off_w == fec_round8(prof_end)
      && fec_round8(req_end) == len;
    result.frame_ok       = ok;
    result.profile_base   = ok ? FIELD_BITS'(HEADER_BYTES) : '0;
    result.profile_length = ok ? snap.prof_len[FIELD_BITS-1:0] : '0;
    result.request_base   = ok ? snap.req_off[FIELD_BITS-1:0] : '0;
    result.request_length = ok ? snap.req_len[FIELD_BITS-1:0] : '0;
  end

endmodule

### src/fec_rq.sv
// small result queue in front of the verdict channel
module fec_rq
  import fec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  fec_result_t push_data,
  input  logic        pop,
  output logic        not_empty,
  output fec_result_t head
);
  `include "assert_macros.svh"

  fec_result_t            slots [RQ_DEPTH];
  logic [RQ_PTR_BITS-1:0] wr_ptr;
  logic [RQ_PTR_BITS-1:0] rd_ptr;
  logic [CREDIT_BITS-1:0] count;

  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `FEC_ASSERT_IMP(a_no_overflow, clk, rst, push,
                  count != CREDIT_BITS'(RQ_DEPTH) || pop)
  `FEC_ASSERT_IMP(a_no_underflow, clk, rst, pop, count != '0)

endmodule

### src/frame_envelope_checker_top.sv
// top level of the frame envelope checker
//
//   channel  | role | payload
//   frame    | sink | data_byte, last_byte
//   result   | src  | frame_ok, profile/request base and length
//   apb      | cfg  | max_frame_bytes at byte address 0
//
// one byte per cycle while frame.ready is high; a verdict passes the s1 stage, snap and the result queue
// a credit count over the four-entry result queue sets frame.ready
// result stalls only hold back bytes once four verdicts are pending
// rst is synchronous; the limit returns to 4194304 and frame state clears
module frame_envelope_checker_top
  import fec_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  fec_byte_if.sink                 frame,
  fec_result_if.source             result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [WORD_BITS-1:0]     pwdata,
  output logic [WORD_BITS-1:0]     prdata,
  output logic                     pready
);
  `include "assert_macros.svh"

  logic [FIELD_BITS-1:0]  max_frame_bytes;
  logic [CREDIT_BITS-1:0] credits;
  logic                   take;
  logic                   pop;
  logic                   snap_valid;
  fec_snap_t              snap;
  fec_result_t            verdict;
  fec_result_t            head;

  assign frame.ready = credits != CREDIT_BITS'(RQ_DEPTH);
  assign take        = frame.valid && frame.ready;
  assign pop         = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else if ((take && frame.last_byte) && !pop) begin
      credits <= credits + 1'b1;
    end else if (pop && !(take && frame.last_byte)) begin
      credits <= credits - 1'b1;
    end
  end

  fec_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .max_frame_bytes (max_frame_bytes)
  );

  fec_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .data_byte  (frame.data_byte),
    .last_byte  (frame.last_byte),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  fec_judge u_judge (
    .snap            (snap),
    .max_frame_bytes (max_frame_bytes),
    .result          (verdict)
  );

  fec_rq u_rq (
    .clk       (clk),
    .rst       (rst),
    .push      (snap_valid),
    .push_data (verdict),
    .pop       (pop),
    .not_empty (result.valid),
    .head      (head)
  );

  assign result.frame_ok       = head.frame_ok;
  assign result.profile_base   = head.profile_base;
  assign result.profile_length = head.profile_length;
  assign result.request_base   = head.request_base;
  assign result.request_length = head.request_length;

  `FEC_ASSERT_IMP(a_credit_bound, clk, rst, 1'b1, credits <= CREDIT_BITS'(RQ_DEPTH))
  `FEC_ASSERT_IMP(a_valid_has_credit, clk, rst, result.valid, credits != '0)

endmodule

### bench/tb_frame_envelope_checker_top.sv
// self-checking testbench for frame_envelope_checker_top, scored per verdict
`timescale 1ns / 1ps

module tb_frame_envelope_checker_top;
  import fec_pkg::*;

  localparam logic [63:0] FRAME_MAGIC = "BGCCABI1";
  localparam int TOTAL_AT = 16;
  localparam int PROF_LEN_AT = 28;
  localparam int REQ_OFF_AT = 32;
  localparam int REQ_LEN_AT = 36;
  localparam logic [CFG_ADDR_BITS-1:0] MAX_FRAME_ADDR = CFG_ADDR_BITS'(4 * CFG_IDX_MAX_FRAME);
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES = 6;
  localparam int FRAMES_PER_PHASE = 1;
  localparam int MAX_PRINTED = 50;

  typedef enum {
    FLIP_HEADER_BIT, DIRTY_PADDING, CUT_TAIL, GROW_TAIL, SCRAMBLE_FIELD, ZERO_LENGTH,
    SKEW_OFFSET
  } mangle_kind_t;

  class envelope_board_t;
    logic [FIELD_BITS-1:0]    limit_reg;
    logic [POSITION_BITS-1:0] position;
    bit                       hdr_ok;
    bit                       pad_ok;
    logic [31:0]              total;
    logic [31:0]              prof_len;
    logic [31:0]              req_off;
    logic [31:0]              req_len;
    fec_result_t              verdicts_due[$];
    int                       errors;
    int                       bytes_seen;
    int                       verdicts_seen;
    int                       passes_seen;

    function new();
      limit_reg = ABS_MAX_FRAME;
      clear_frame();
    endfunction

    function void clear_frame();
      position = '0;
      hdr_ok = 1'b1;
      pad_ok = 1'b1;
      total = '0;
      prof_len = '0;
      req_off = '0;
      req_len = '0;
    endfunction

    function void set_limit(logic [31:0] value);
      limit_reg = value[FIELD_BITS-1:0];
    endfunction

    function longint unsigned up8(longint unsigned x);
      return (x + ALIGN_BYTES - 1) & ~64'(ALIGN_BYTES - 1);
    endfunction

    function void take_byte(logic [7:0] b, logic is_last);
      longint unsigned hpos;
      longint unsigned prof_end;
      longint unsigned req_end;
      longint unsigned len;
      longint unsigned lim;
      logic [7:0]      want;
      logic [4:0]      sh;
      bit              ok;
      fec_result_t     v;
      hpos = position;
      sh = {hpos[1:0], 3'b000};
      bytes_seen++;
      prof_end = 64'(HEADER_BYTES) + 64'(prof_len);
      req_end = 64'(req_off) + 64'(req_len);
      if (hpos < HEADER_BYTES) begin
        want = 8'h00;
        if (hpos < 8) begin
          want = FRAME_MAGIC[8 * (7 - hpos) +: 8];
        end else if (hpos == POS_VERSION) begin
          want = VERSION_BYTE;
        end else if (hpos == POS_HDR_SIZE || hpos == POS_PROF_OFF) begin
          want = HDR_SIZE_BYTE;
        end
        if (hpos >= TOTAL_AT && hpos < TOTAL_AT + 4) begin
          total |= 32'(b) << sh;
        end else if (hpos >= PROF_LEN_AT && hpos < PROF_LEN_AT + 4) begin
          prof_len |= 32'(b) << sh;
        end else if (hpos >= REQ_OFF_AT && hpos < REQ_OFF_AT + 4) begin
          req_off |= 32'(b) << sh;
        end else if (hpos >= REQ_LEN_AT && hpos < REQ_LEN_AT + 4) begin
          req_len |= 32'(b) << sh;
        end else if (b != want) begin
          hdr_ok = 1'b0;
        end
      end else if (b != 8'h00 && ((hpos >= prof_end && hpos < 64'(req_off)) || hpos >= req_end)) begin
        pad_ok = 1'b0;
      end
      if (!is_last) begin
        if (position != '1) position++;
        return;
      end
      len = hpos + 1;
      lim = (limit_reg > ABS_MAX_FRAME) ? 64'(ABS_MAX_FRAME) : 64'(limit_reg);
      ok = hdr_ok && pad_ok && position != '1 && len >= HEADER_BYTES && len <= lim
        && 64'(total) == len && prof_len != 0 && req_len != 0
        && (64'(req_off) % ALIGN_BYTES) == 0
        && prof_end <= len && req_end <= len
        && 64'(req_off) == up8(prof_end) && up8(req_end) == len;
      v = '0;
      if (ok) begin
        v.frame_ok = 1'b1;
        v.profile_base = FIELD_BITS'(HEADER_BYTES);
        v.profile_length = prof_len[FIELD_BITS-1:0];
        v.request_base = req_off[FIELD_BITS-1:0];
        v.request_length = req_len[FIELD_BITS-1:0];
      end
      verdicts_due.push_back(v);
      clear_frame();
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("mismatch at verdict %0d, %s: got 0x%0h, want 0x%0h", verdicts_seen, what,
                 got, want);
    endtask

    task check_result(fec_result_t got);
      fec_result_t want;
      if (verdicts_due.size() == 0) begin
        report_mismatch("verdict with nothing due", got.frame_ok, 0);
        return;
      end
      want = verdicts_due.pop_front();
      verdicts_seen++;
      if (want.frame_ok) passes_seen++;
      if (got.frame_ok !== want.frame_ok)
        report_mismatch("frame_ok", got.frame_ok, want.frame_ok);
      if (got.profile_base !== want.profile_base)
        report_mismatch("profile_base", got.profile_base, want.profile_base);
      if (got.profile_length !== want.profile_length)
        report_mismatch("profile_length", got.profile_length, want.profile_length);
      if (got.request_base !== want.request_base)
        report_mismatch("request_base", got.request_base, want.request_base);
      if (got.request_length !== want.request_length)
        report_mismatch("request_length", got.request_length, want.request_length);
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [WORD_BITS-1:0]     pwdata;
  logic [WORD_BITS-1:0]     prdata;
  logic                     pready;

  fec_byte_if   frame_ch();
  fec_result_if result_ch();

  envelope_board_t board;
  logic [7:0] frame_buf[$];
  bit         idle_on;
  bit         hold_req;
  int         limit_writes;
  int         input_stalls;
  int         quiet_cycles;

  frame_envelope_checker_top dut (
    .clk(clk),
    .rst(rst),
    .frame(frame_ch),
    .result(result_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // score every transfer on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (frame_ch.valid && frame_ch.ready)
        board.take_byte(frame_ch.data_byte, frame_ch.last_byte);
      if (frame_ch.valid && !frame_ch.ready) input_stalls++;
      if (result_ch.valid && result_ch.ready)
        board.check_result(fec_result_t'{result_ch.frame_ok, result_ch.profile_base,
                                         result_ch.profile_length, result_ch.request_base,
                                         result_ch.request_length});
    end
  end

  always @(posedge clk) begin
    if (rst || (frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)
        || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        result_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    if (idle_on && $urandom_range(0, 6) == 0) begin
      frame_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    frame_ch.valid <= 1'b1;
    frame_ch.data_byte <= b;
    frame_ch.last_byte <= is_last;
    do @(posedge clk); while (frame_ch.ready !== 1'b1);
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic drain_verdicts();
    frame_ch.valid <= 1'b0;
    do @(posedge clk); while (board.verdicts_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame_limit(input logic [WORD_BITS-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MAX_FRAME_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    board.set_limit(value);
    limit_writes++;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== WORD_BITS'(board.limit_reg))
      board.report_mismatch("max_frame_bytes readback", prdata, board.limit_reg);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void put_word(int at, logic [31:0] w);
    for (int k = 0; k < 4; k++) frame_buf[at + k] = w[8 * k +: 8];
  endfunction

  function automatic void build_good(int plen, int rlen);
    int prof_end;
    int roff;
    int req_end;
    int total;
    frame_buf.delete();
    prof_end = HEADER_BYTES + plen;
    roff = (prof_end + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
    req_end = roff + rlen;
    total = (req_end + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
    for (int p = 0; p < total; p++) begin
      if (p < HEADER_BYTES || (p >= prof_end && p < roff) || p >= req_end)
        frame_buf.push_back(8'h00);
      else
        frame_buf.push_back(8'($urandom));
    end
    for (int k = 0; k < 8; k++) frame_buf[k] = FRAME_MAGIC[8 * (7 - k) +: 8];
    frame_buf[POS_VERSION] = VERSION_BYTE;
    frame_buf[POS_HDR_SIZE] = HDR_SIZE_BYTE;
    frame_buf[POS_PROF_OFF] = HDR_SIZE_BYTE;
    put_word(TOTAL_AT, total);
    put_word(PROF_LEN_AT, plen);
    put_word(REQ_OFF_AT, roff);
    put_word(REQ_LEN_AT, rlen);
  endfunction

  function automatic void mangle_frame(mangle_kind_t how);
    int at;
    int n;
    logic [31:0] w;
    w = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 400);
    case (how)
      FLIP_HEADER_BIT: begin
        at = $urandom_range(0, HEADER_BYTES - 1);
        frame_buf[at] ^= 8'(1 << $urandom_range(0, 7));
      end
      DIRTY_PADDING: begin
        at = $urandom_range(HEADER_BYTES, frame_buf.size() - 1);
        frame_buf[at] = 8'($urandom_range(1, 255));
      end
      CUT_TAIL: begin
        n = $urandom_range(1, 12);
        repeat (n) void'(frame_buf.pop_back());
      end
      GROW_TAIL: begin
        n = $urandom_range(1, 12);
        repeat (n) frame_buf.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
      end
      SCRAMBLE_FIELD: begin
        case ($urandom_range(0, 3))
          0: put_word(TOTAL_AT, w);
          1: put_word(PROF_LEN_AT, w);
          2: put_word(REQ_OFF_AT, w);
          default: put_word(REQ_LEN_AT, w);
        endcase
      end
      ZERO_LENGTH: put_word(($urandom_range(0, 1) == 0) ? PROF_LEN_AT : REQ_LEN_AT, 32'd0);
      SKEW_OFFSET: frame_buf[REQ_OFF_AT] += 8'($urandom_range(1, ALIGN_BYTES - 1));
      default: ;
    endcase
  endfunction

  initial begin
    int kind;
    int plen;
    int rlen;
    board = new();
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= MAX_FRAME_ADDR;
    pwdata <= '0;
    frame_ch.valid <= 1'b0;
    frame_ch.data_byte <= 8'h00;
    frame_ch.last_byte <= 1'b0;
    idle_on = 1'b0;
    hold_req = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames at the reset limit
    build_good(1, 1); send_frame();
    frame_buf = '{8'hFF}; send_frame();
    frame_buf = '{8'h00}; send_frame();
    build_good(1, 1); repeat (17) void'(frame_buf.pop_back()); send_frame();
    build_good(1, 1); repeat (16) void'(frame_buf.pop_back()); send_frame();
    build_good(2, 3); frame_buf[POS_VERSION] = 8'h02; send_frame();
    build_good(2, 3); frame_buf[HEADER_BYTES - 1] = 8'h01; send_frame();
    build_good(3, 5); frame_buf[70] = 8'h01; send_frame();
    build_good(1, 3); frame_buf[79] = 8'h80; send_frame();
    build_good(4, 4); put_word(TOTAL_AT, frame_buf.size() + 8); send_frame();
    build_good(4, 4); put_word(PROF_LEN_AT, 32'hFFFF_FFFF); send_frame();
    build_good(4, 4); put_word(REQ_OFF_AT, 32'hFFFF_FFF8); put_word(REQ_LEN_AT, 32'hFFFF_FFFF);
    send_frame();
    drain_verdicts();

    // limit edges: exact fit, eight bytes over, below the header
    set_frame_limit(32'd80);
    build_good(1, 1); send_frame();
    build_good(1, 9); send_frame();
    drain_verdicts();
    set_frame_limit(32'd63);
    build_good(1, 1); send_frame();
    drain_verdicts();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_frame_limit(WORD_BITS'(ABS_MAX_FRAME));
        1: set_frame_limit($urandom_range(80, 300));
        2: set_frame_limit(32'd64);
        3: set_frame_limit($urandom_range(0, (1 << FIELD_BITS) - 1));
        4: set_frame_limit(32'((1 << FIELD_BITS) - 1));
        default: set_frame_limit(WORD_BITS'(ABS_MAX_FRAME));
      endcase
      if (phase == 2) begin
        // long result hold-off with short frames queued behind it
        idle_on = 1'b0;
        hold_req = 1'b1;
        repeat (16) begin
          frame_buf = '{8'($urandom)};
          send_frame();
        end
      end
      for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
        idle_on = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
        kind = $urandom_range(0, 99);
        plen = $urandom_range(1, 16);
        rlen = $urandom_range(1, 16);
        if (kind < 45) begin
          build_good(plen, rlen);
        end else if (kind < 75) begin
          build_good(plen, rlen);
          repeat ($urandom_range(1, 2))
            mangle_frame(mangle_kind_t'($urandom_range(0, int'(SKEW_OFFSET))));
        end else begin
          frame_buf.delete();
          repeat ($urandom_range(1, 40)) frame_buf.push_back(8'($urandom));
        end
        send_frame();
      end
      drain_verdicts();
    end

    $display("run covered %0d bytes and %0d verdicts (%0d passing) over %0d limit writes",
             board.bytes_seen, board.verdicts_seen, board.passes_seen, limit_writes);
    $display("byte input was held back for %0d cycles by result back-pressure", input_stalls);
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
